// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clk_i with reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RGBHSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define RGBHSL_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`else
`define RGBHSL_ASSERT(lbl, prop)
`define RGBHSL_NEVER(lbl, expr)
`endif

`endif

// ----- rtl/rgbhsl_pkg.sv -----
package rgbhsl_pkg;

  localparam int unsigned QDepth = 2;
  localparam logic [15:0] NeutralReset = 16'd5000;
  localparam logic [21:0] HueFull = 22'd3840000;
  localparam logic [24:0] FineMax = 25'd23040000;
  localparam logic [14:0] SatMax = 15'd25600;
  localparam logic [20:0] RecipLight = 21'd1342177;
  localparam logic [17:0] RecipHue = 18'd134217;

  typedef struct packed {
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;
    logic [15:0] clear_count;
    logic [15:0] temperature_kelvin;
    logic [15:0] illuminance_lux;
  } rgbhsl_in_t;

  typedef struct packed {
    logic [14:0] hue_q6;
    logic [14:0] saturation_pct_q8;
    logic [17:0] lightness_pct_q8;
  } rgbhsl_out_t;

  // queue entry: counts, divisor with zero fixed, and which channels saturate
  typedef struct packed {
    logic [2:0][15:0] cnt;
    logic [15:0]      clr;
    logic [2:0]       big;
    logic [15:0]      temp;
    logic [15:0]      lux;
  } rgbhsl_qitem_t;

endpackage

// ----- rtl/rgbhsl_front.sv -----
module rgbhsl_front import rgbhsl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rgbhsl_in_t    in_data_i,
  output logic          in_ready_o,
  output rgbhsl_qitem_t q_item_o,
  output logic          q_valid_o,
  input  logic          q_pop_i
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  rgbhsl_qitem_t      mem_q [QDepth];
  rgbhsl_qitem_t      item;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  always_comb begin
    item.cnt[0] = in_data_i.red_count;
    item.cnt[1] = in_data_i.green_count;
    item.cnt[2] = in_data_i.blue_count;
    item.clr    = (in_data_i.clear_count == 16'd0) ? 16'd1 : in_data_i.clear_count;
    item.temp   = in_data_i.temperature_kelvin;
    item.lux    = in_data_i.illuminance_lux;
    // a count at or above clear gives a ratio of one or more
    for (int c = 0; c < 3; c++) begin
      item.big[c] = item.cnt[c] >= item.clr;
    end
  end

  assign in_ready_o = cnt_q != CntW'(QDepth);
  assign q_valid_o  = cnt_q != '0;
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- rtl/rgbhsl_back.sv -----
module rgbhsl_back import rgbhsl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rgbhsl_qitem_t q_item_i,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  logic [15:0]   neutral_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rgbhsl_out_t   out_data_o
);

  localparam int unsigned NSt = 17;
  localparam int unsigned DSt = 23;
  localparam int unsigned StC = NSt + 1;
  localparam int unsigned StE1 = StC + DSt + 1;
  localparam int unsigned NVld = StE1 + 3;

  typedef struct packed {
    logic [2:0][15:0] rem;
    logic [2:0][15:0] quo;
    logic [2:0]       big;
    logic [15:0]      clr;
    logic [15:0]      temp;
    logic [15:0]      lux;
  } nst_t;

  typedef struct packed {
    logic [16:0] d;
    logic [17:0] s;
    logic [16:0] adiff;
    logic        neg;
    logic [2:0]  off;
    logic [18:0] dd;
    logic        dz;
    logic [15:0] temp;
    logic [15:0] lux;
  } bst_t;

  typedef struct packed {
    logic [38:0] nh;
    logic [40:0] ns;
    logic [35:0] x;
    logic [16:0] d;
    logic [18:0] dd;
    logic        neg;
    logic [2:0]  off;
    logic        dz;
    logic [15:0] temp;
  } cst_t;

  typedef struct packed {
    logic [38:0] rh;
    logic [21:0] qh;
    logic [16:0] dh;
    logic [40:0] rs;
    logic [14:0] qs;
    logic [18:0] dd;
    logic        sov;
    logic [35:0] x;
    logic        neg;
    logic [2:0]  off;
    logic        dz;
    logic [15:0] temp;
  } dst_t;

  function automatic nst_t nstep(nst_t a);
    nst_t        o;
    logic [16:0] t;
    o = a;
    for (int c = 0; c < 3; c++) begin
      t = {a.rem[c], 1'b0};
      if (t >= {1'b0, a.clr}) begin
        o.rem[c] = 16'(t - {1'b0, a.clr});
        o.quo[c] = {a.quo[c][14:0], 1'b1};
      end else begin
        o.rem[c] = t[15:0];
        o.quo[c] = {a.quo[c][14:0], 1'b0};
      end
    end
    return o;
  endfunction

  // one quotient bit of hue and, from bit 14 down, of saturation
  function automatic dst_t dstep(dst_t a, int b);
    dst_t        o;
    logic [38:0] sh;
    logic [40:0] ss;
    o  = a;
    sh = 39'(a.dh) << b;
    ss = 41'(a.dd) << b;
    if (a.rh >= sh) begin
      o.rh    = a.rh - sh;
      o.qh[b] = 1'b1;
    end
    if (b <= 14) begin
      if (a.rs >= ss) begin
        o.rs    = a.rs - ss;
        o.qs[b] = 1'b1;
      end
    end
    return o;
  endfunction

  nst_t        ns_q [NSt];
  bst_t        b_q, b_d;
  cst_t        c_q, c_d;
  dst_t        dv_q [DSt];
  dst_t        dv0;
  logic [NVld-1:0] vld_q;
  logic        en;

  logic [24:0] fine_q, fine_d;
  logic [14:0] sat1_q, sat2_q;
  logic [24:0] ly_q;
  logic [20:0] lq0_q, lq0_d;
  logic [21:0] hy2_q;
  logic [15:0] hq0_q, hq0_d;
  logic [17:0] light2_q, light_d;
  logic [14:0] hue_d;
  rgbhsl_out_t out_q;

  assign en          = !vld_q[NVld-1] || out_ready_i;
  assign q_pop_o     = en;
  assign out_valid_o = vld_q[NVld-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NVld-2:0], q_valid_i};
    end
  end

  // normalization: one quotient bit per stage for all three channels
  always_ff @(posedge clk_i) begin
    if (en) begin
      ns_q[0].rem  <= q_item_i.cnt;
      ns_q[0].quo  <= '0;
      ns_q[0].big  <= q_item_i.big;
      ns_q[0].clr  <= q_item_i.clr;
      ns_q[0].temp <= q_item_i.temp;
      ns_q[0].lux  <= q_item_i.lux;
    end
  end

  for (genvar j = 0; j < NSt - 1; j++) begin : g_norm
    always_ff @(posedge clk_i) begin
      if (en) begin
        ns_q[j+1] <= nstep(ns_q[j]);
      end
    end
  end

  // max, min and hue sector
  always_comb begin
    logic [16:0] n [3];
    logic [16:0] mx, mn, den;
    for (int c = 0; c < 3; c++) begin
      n[c] = ns_q[NSt-1].big[c] ? 17'h10000 : {1'b0, ns_q[NSt-1].quo[c]};
    end
    mx = (n[0] > n[1]) ? n[0] : n[1];
    mx = (mx > n[2]) ? mx : n[2];
    mn = (n[0] < n[1]) ? n[0] : n[1];
    mn = (mn < n[2]) ? mn : n[2];
    b_d.d    = mx - mn;
    b_d.s    = 18'(mx) + 18'(mn);
    b_d.dz   = b_d.d == 17'd0;
    b_d.temp = ns_q[NSt-1].temp;
    b_d.lux  = ns_q[NSt-1].lux;
    if (mx == n[0]) begin
      b_d.neg   = n[1] < n[2];
      b_d.adiff = b_d.neg ? n[2] - n[1] : n[1] - n[2];
      b_d.off   = b_d.neg ? 3'd6 : 3'd0;
    end else if (mx == n[1]) begin
      b_d.neg   = n[2] < n[0];
      b_d.adiff = b_d.neg ? n[0] - n[2] : n[2] - n[0];
      b_d.off   = 3'd2;
    end else begin
      b_d.neg   = n[0] < n[1];
      b_d.adiff = b_d.neg ? n[1] - n[0] : n[0] - n[1];
      b_d.off   = 3'd4;
    end
    den    = (b_d.s <= 18'h10000) ? b_d.s[16:0] : 17'(18'h20000 - b_d.s);
    b_d.dd = b_d.dz ? 19'd1 : 19'(den) * 19'd5;
  end

  always_comb begin
    logic [33:0] sp;
    c_d.nh   = 39'(b_q.adiff) * 39'(HueFull);
    sp       = 34'(b_q.d) * 34'(17'(b_q.lux) + 17'd1000);
    c_d.ns   = {sp, 7'b0};
    c_d.x    = 36'(b_q.s) * 36'(17'(b_q.lux) + 17'd8000) + 36'd25600;
    c_d.d    = b_q.d;
    c_d.dd   = b_q.dd;
    c_d.neg  = b_q.neg;
    c_d.off  = b_q.off;
    c_d.dz   = b_q.dz;
    c_d.temp = b_q.temp;
  end

  always_comb begin
    dv0.rh   = c_q.nh;
    dv0.qh   = '0;
    dv0.dh   = c_q.dz ? 17'd1 : c_q.d;
    dv0.rs   = c_q.ns;
    dv0.qs   = '0;
    dv0.dd   = c_q.dd;
    dv0.sov  = c_q.ns >= 41'(c_q.dd) * 41'(SatMax);
    dv0.x    = c_q.x;
    dv0.neg  = c_q.neg;
    dv0.off  = c_q.off;
    dv0.dz   = c_q.dz;
    dv0.temp = c_q.temp;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q     <= b_d;
      c_q     <= c_d;
      dv_q[0] <= dv0;
    end
  end

  for (genvar i = 0; i < DSt - 1; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[i+1] <= dstep(dv_q[i], DSt - 2 - i);
      end
    end
  end

  // hue shift and clamp, lightness reciprocal product
  always_comb begin
    logic [27:0]        offv, qv;
    logic signed [27:0] base, tsh, fsum;
    logic [45:0]        lp;
    offv = 28'(dv_q[DSt-1].off) * 28'(HueFull);
    qv   = 28'(dv_q[DSt-1].qh) + 28'(dv_q[DSt-1].neg && (|dv_q[DSt-1].rh));
    base = dv_q[DSt-1].dz ? 28'sd0 : $signed(dv_q[DSt-1].neg ? offv - qv : offv + qv);
    tsh  = ($signed({12'b0, dv_q[DSt-1].temp}) - $signed({12'b0, neutral_i})) <<< 6;
    fsum = base + tsh;
    if (fsum < 0) begin
      fine_d = '0;
    end else if (fsum > $signed({3'b0, FineMax})) begin
      fine_d = FineMax;
    end else begin
      fine_d = fsum[24:0];
    end
    lp    = 46'(dv_q[DSt-1].x[35:11]) * 46'(RecipLight);
    lq0_d = lp[45:25];
  end

  always_comb begin
    logic [39:0] hp;
    logic [24:0] lr;
    hp      = 40'(fine_q[24:3]) * 40'(RecipHue);
    hq0_d   = hp[39:24];
    lr      = ly_q - 25'(lq0_q) * 25'd25;
    light_d = 18'(lq0_q + 21'(lr >= 25'd25));
  end

  always_comb begin
    logic [21:0] hr;
    hr    = hy2_q - 22'(hq0_q) * 22'd125;
    hue_d = 15'(hq0_q + 16'(hr >= 22'd125));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fine_q   <= fine_d;
      sat1_q   <= dv_q[DSt-1].sov ? SatMax : dv_q[DSt-1].qs;
      ly_q     <= dv_q[DSt-1].x[35:11];
      lq0_q    <= lq0_d;
      hy2_q    <= fine_q[24:3];
      hq0_q    <= hq0_d;
      sat2_q   <= sat1_q;
      light2_q <= light_d;
      out_q.hue_q6            <= hue_d;
      out_q.saturation_pct_q8 <= sat2_q;
      out_q.lightness_pct_q8  <= light2_q;
    end
  end

endmodule

// ----- rtl/rgb_to_hsl_light_adjust.sv -----
// Color sensor to HSL converter with lux and color temperature adjustment.
// One item is accepted per clock while out_ready_i does not stall the pipe;
// one result leaves per item, in order, through the normalization divider
// (16 stages) and the hue divider (22 stages, one quotient bit per stage,
// with saturation sharing the same stages). A two-item input queue decouples
// in_ready_o from out_ready_i. Write neutral_temperature through the cfg
// channel (reset 5000) only while the block is idle, which it does not enforce.
`include "assert_macros.svh"

module rgb_to_hsl_light_adjust import rgbhsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rgbhsl_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rgbhsl_out_t out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]   neutral_q;
  rgbhsl_qitem_t q_item;
  logic          q_valid;
  logic          q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= NeutralReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      neutral_q <= cfg_data_i;
    end
  end

  rgbhsl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_item_o   (q_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop)
  );

  rgbhsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_item_i    (q_item),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .neutral_i   (neutral_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `RGBHSL_ASSERT(a_hue_range, out_valid_o |-> out_data_o.hue_q6 <= 15'd23040)
  `RGBHSL_ASSERT(a_sat_range, out_valid_o |-> out_data_o.saturation_pct_q8 <= SatMax)
  `RGBHSL_NEVER(a_light_range, out_valid_o && out_data_o.lightness_pct_q8 > 18'd188250)

endmodule
